>>> hw/rtl/fcd_pkg.sv
// Shared constants, payload types and control structs for the fixed capacity deque.
`timescale 1ns / 1ps

package fcd_pkg;

  localparam int CAPACITY   = 8;
  localparam int WORD_WIDTH = 32;
  localparam int KIND_W     = 3;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SUM_W      = CNT_W + 1;

  localparam logic [KIND_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] OP_CLEAR      = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]            kind;
    logic signed [WORD_WIDTH-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic                         ok;
    logic signed [WORD_WIDTH-1:0] popped;
    logic signed [WORD_WIDTH-1:0] front_word;
    logic signed [WORD_WIDTH-1:0] back_word;
    logic [CNT_W-1:0]             fill_count;
    logic                         is_empty;
    logic                         is_full;
  } out_rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic fetch;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_fetch;
  } sts_t;

endpackage

>>> hw/rtl/fixed_capacity_deque.sv
// Top level of the fixed capacity double-ended queue.
`timescale 1ns / 1ps

// Each accepted request passes through an update state and then a result load state, and a
// pop that leaves at least one element adds a fetch state between them because the new
// end word is read back from the single-read-port slot memory with registered data. A new
// request is taken only when the previous one has reached the output register, so the block
// does not take a new request before it is through with the last one; the output register
// lets a finished result wait while the next request is accepted.
// The front and back words are held in registers, so status never needs a second read.
module fixed_capacity_deque (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fcd_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fcd_pkg::out_rsp_t  out_data
);

  fcd_pkg::cmd_t cmd;
  fcd_pkg::sts_t sts;

  fcd_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fcd_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

>>> hw/rtl/fcd_controller.sv
// Sequencing state machine for the fixed capacity deque.
`timescale 1ns / 1ps

module fcd_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  fcd_pkg::sts_t sts,
  output fcd_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FETCH,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_fetch ? S_FETCH : S_DONE;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/fcd_datapath.sv
// Slot memory, ring pointers, cached end words and result register of the deque.
`timescale 1ns / 1ps

module fcd_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  fcd_pkg::in_req_t in_data,
  input  fcd_pkg::cmd_t    cmd,
  output fcd_pkg::sts_t    sts,
  output fcd_pkg::out_rsp_t out_data
);

  localparam int IDX_W = fcd_pkg::IDX_W;
  localparam int CNT_W = fcd_pkg::CNT_W;
  localparam int SUM_W = fcd_pkg::SUM_W;
  localparam int WW    = fcd_pkg::WORD_WIDTH;
  localparam int CAP   = fcd_pkg::CAPACITY;

  logic [WW-1:0] mem [CAP];

  logic [fcd_pkg::KIND_W-1:0] kind_r;
  logic signed [WW-1:0]       value_r;
  logic [IDX_W-1:0]           head_r;
  logic [IDX_W-1:0]           head_nxt;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           count_nxt;
  logic signed [WW-1:0]       front_r;
  logic signed [WW-1:0]       front_nxt;
  logic signed [WW-1:0]       back_r;
  logic signed [WW-1:0]       back_nxt;
  logic                       ok_r;
  logic                       ok_nxt;
  logic signed [WW-1:0]       popped_r;
  logic signed [WW-1:0]       popped_nxt;
  logic                       fetch_front_r;
  logic                       fetch_front_nxt;
  logic                       fetch_nxt;
  logic [WW-1:0]              rdata_r;
  logic                       we;
  logic [IDX_W-1:0]           waddr;
  logic [IDX_W-1:0]           raddr;
  logic [IDX_W-1:0]           head_inc;
  logic [IDX_W-1:0]           head_dec;
  logic [SUM_W-1:0]           tail_sum;
  logic [IDX_W-1:0]           tail_addr;
  logic [IDX_W-1:0]           prev_addr;
  logic                       is_empty;
  logic                       not_full;
  fcd_pkg::out_rsp_t          out_r;

  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] x);
    logic [SUM_W-1:0] y;
    begin
      y = (x >= SUM_W'(CAP)) ? x - SUM_W'(CAP) : x;
      return y[IDX_W-1:0];
    end
  endfunction

  assign head_inc  = (head_r == IDX_W'(CAP - 1)) ? '0 : head_r + 1'b1;
  assign head_dec  = (head_r == '0) ? IDX_W'(CAP - 1) : head_r - 1'b1;
  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_addr = wrap_idx(tail_sum);
  assign prev_addr = wrap_idx(tail_sum - SUM_W'(2));
  assign is_empty  = (count_r == '0);
  assign not_full  = (count_r != CNT_W'(CAP));

  always_comb begin
    head_nxt        = head_r;
    count_nxt       = count_r;
    front_nxt       = front_r;
    back_nxt        = back_r;
    ok_nxt          = 1'b0;
    popped_nxt      = '0;
    we              = 1'b0;
    waddr           = head_dec;
    raddr           = head_inc;
    fetch_nxt       = 1'b0;
    fetch_front_nxt = 1'b1;
    case (kind_r)
      fcd_pkg::OP_PUSH_FRONT: begin
        if (not_full) begin
          head_nxt  = head_dec;
          count_nxt = count_r + 1'b1;
          front_nxt = value_r;
          if (is_empty) begin
            back_nxt = value_r;
          end
          we     = 1'b1;
          waddr  = head_dec;
          ok_nxt = 1'b1;
        end
      end
      fcd_pkg::OP_PUSH_BACK: begin
        if (not_full) begin
          count_nxt = count_r + 1'b1;
          back_nxt  = value_r;
          if (is_empty) begin
            front_nxt = value_r;
          end
          we     = 1'b1;
          waddr  = tail_addr;
          ok_nxt = 1'b1;
        end
      end
      fcd_pkg::OP_POP_FRONT: begin
        if (!is_empty) begin
          popped_nxt = front_r;
          head_nxt   = head_inc;
          count_nxt  = count_r - 1'b1;
          raddr      = head_inc;
          fetch_nxt  = (count_r > CNT_W'(1));
          ok_nxt     = 1'b1;
        end
      end
      fcd_pkg::OP_POP_BACK: begin
        if (!is_empty) begin
          popped_nxt      = back_r;
          count_nxt       = count_r - 1'b1;
          raddr           = prev_addr;
          fetch_nxt       = (count_r > CNT_W'(1));
          fetch_front_nxt = 1'b0;
          ok_nxt          = 1'b1;
        end
      end
      fcd_pkg::OP_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
        ok_nxt    = 1'b1;
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  assign sts.need_fetch = fetch_nxt;

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[waddr] <= value_r;
    end
    if (cmd.exec) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_data.kind;
      value_r <= in_data.value;
    end
    if (cmd.exec) begin
      front_r       <= front_nxt;
      back_r        <= back_nxt;
      ok_r          <= ok_nxt;
      popped_r      <= popped_nxt;
      fetch_front_r <= fetch_front_nxt;
    end else if (cmd.fetch) begin
      if (fetch_front_r) begin
        front_r <= rdata_r;
      end else begin
        back_r <= rdata_r;
      end
    end
    if (cmd.out_load) begin
      out_r.ok         <= ok_r;
      out_r.popped     <= popped_r;
      out_r.front_word <= is_empty ? '0 : front_r;
      out_r.back_word  <= is_empty ? '0 : back_r;
      out_r.fill_count <= count_r;
      out_r.is_empty   <= is_empty;
      out_r.is_full    <= !not_full;
    end
  end

  assign out_data = out_r;

endmodule

>>> hw/rtl/fcd_checker.sv
// Port-level checker for the fixed capacity deque and its bind to the top level.
`timescale 1ns / 1ps

module fcd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input fcd_pkg::in_req_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input fcd_pkg::out_rsp_t out_data
);

  a_status_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.fill_count == '0)) &&
      (out_data.is_full == (out_data.fill_count == fcd_pkg::CNT_W'(fcd_pkg::CAPACITY))))
    else $error("status flags disagree with fill_count");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |-> (out_data.front_word == '0) &&
      (out_data.back_word == '0))
    else $error("end words not zero on an empty deque");

  a_failed_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> (out_data.popped == '0))
    else $error("popped word set on a failed request");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("request changed while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind fixed_capacity_deque fcd_checker u_fcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/fixed_capacity_deque_test.sv
// Self-checking testbench for the fixed capacity deque: a directed table, then random requests.
`timescale 1ns / 1ps

module fixed_capacity_deque_test;
  import fcd_pkg::*;

  localparam int RANDOM_REQS  = 800;
  localparam int STALL_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AT      = 300;
  localparam int SETTLE_AT    = 550;

  localparam logic [KIND_W-1:0] KIND_RSVD_LO  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_MID = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_HI  = 3'd7;

  localparam logic signed [WORD_WIDTH-1:0] W_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_WIDTH-1:0] W_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_WIDTH-1:0] W_ALT = 32'shaaaa_aaaa;
  localparam logic signed [WORD_WIDTH-1:0] W_TOP = 32'sd12345;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } dir_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_data;

  logic signed [WORD_WIDTH-1:0] ring [CAPACITY];
  logic [IDX_W-1:0]             head;
  logic [CNT_W-1:0]             count;
  out_rsp_t                     expected_rsps [$];
  out_rsp_t                     oldest_rsp;
  int                           mismatches = 0;
  int                           idle_cycles;
  bit                           hold_req;

  dir_row_t dir_rows [25] = '{
    '{'{OP_POP_FRONT, W_MIN}, 1'b1, '{1'b0, 0, 0, 0, 4'd0, 1'b1, 1'b0}},
    '{'{OP_POP_BACK, W_MAX}, 1'b1, '{1'b0, 0, 0, 0, 4'd0, 1'b1, 1'b0}},
    '{'{KIND_RSVD_LO, W_MAX}, 1'b1, '{1'b0, 0, 0, 0, 4'd0, 1'b1, 1'b0}},
    '{'{OP_PUSH_BACK, W_MAX}, 1'b1, '{1'b1, 0, W_MAX, W_MAX, 4'd1, 1'b0, 1'b0}},
    '{'{OP_PUSH_FRONT, W_MIN}, 1'b1, '{1'b1, 0, W_MIN, W_MAX, 4'd2, 1'b0, 1'b0}},
    '{'{KIND_RSVD_MID, -32'sd1}, 1'b1, '{1'b0, 0, W_MIN, W_MAX, 4'd2, 1'b0, 1'b0}},
    '{'{OP_PUSH_BACK, -32'sd1}, 1'b0, '0},
    '{'{OP_PUSH_FRONT, 32'sd0}, 1'b0, '0},
    '{'{OP_PUSH_BACK, 32'sd1}, 1'b0, '0},
    '{'{OP_PUSH_FRONT, 32'sh5555_5555}, 1'b0, '0},
    '{'{OP_PUSH_BACK, W_ALT}, 1'b0, '0},
    '{'{OP_PUSH_FRONT, W_TOP}, 1'b0, '0},
    '{'{OP_PUSH_BACK, 32'sd7}, 1'b1, '{1'b0, 0, W_TOP, W_ALT, 4'd8, 1'b0, 1'b1}},
    '{'{OP_PUSH_FRONT, -32'sd9}, 1'b0, '0},
    '{'{KIND_RSVD_HI, W_MIN}, 1'b0, '0},
    '{'{OP_POP_FRONT, W_MAX}, 1'b0, '0},
    '{'{OP_POP_BACK, W_MIN}, 1'b0, '0},
    '{'{OP_POP_BACK, -32'sd1}, 1'b0, '0},
    '{'{OP_POP_FRONT, 32'sd0}, 1'b0, '0},
    '{'{OP_CLEAR, W_MAX}, 1'b1, '{1'b1, 0, 0, 0, 4'd0, 1'b1, 1'b0}},
    '{'{OP_POP_BACK, W_MIN}, 1'b1, '{1'b0, 0, 0, 0, 4'd0, 1'b1, 1'b0}},
    '{'{OP_PUSH_FRONT, -32'sd5}, 1'b0, '0},
    '{'{OP_PUSH_BACK, 32'sd3}, 1'b0, '0},
    '{'{OP_POP_FRONT, W_MAX}, 1'b0, '0},
    '{'{OP_POP_BACK, W_MAX}, 1'b0, '0}
  };

  fixed_capacity_deque i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // The slot index wraps at the index width, which matches the power-of-two capacity.
  function automatic out_rsp_t apply_deque_op(in_req_t req);
    out_rsp_t         rsp;
    logic [IDX_W-1:0] tail;
    rsp = '0;
    case (req.kind)
      OP_PUSH_FRONT: begin
        if (count < CAPACITY) begin
          head = head - 1'b1;
          ring[head] = req.value;
          count = count + 1'b1;
          rsp.ok = 1'b1;
        end
      end
      OP_PUSH_BACK: begin
        if (count < CAPACITY) begin
          tail = head + IDX_W'(count);
          ring[tail] = req.value;
          count = count + 1'b1;
          rsp.ok = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (count != 0) begin
          rsp.popped = ring[head];
          head = head + 1'b1;
          count = count - 1'b1;
          rsp.ok = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (count != 0) begin
          tail = head + IDX_W'(count - 1'b1);
          rsp.popped = ring[tail];
          count = count - 1'b1;
          rsp.ok = 1'b1;
        end
      end
      OP_CLEAR: begin
        head = '0;
        count = '0;
        rsp.ok = 1'b1;
      end
      default: begin
      end
    endcase
    if (count != 0) begin
      tail = head + IDX_W'(count - 1'b1);
      rsp.front_word = ring[head];
      rsp.back_word = ring[tail];
    end
    rsp.fill_count = count;
    rsp.is_empty = (count == 0);
    rsp.is_full = (count == CAPACITY);
    return rsp;
  endfunction

  function automatic in_req_t random_deque_req(int push_pct);
    in_req_t req;
    int      roll;
    roll = $urandom_range(99);
    if (roll < 3) begin
      req.kind = OP_CLEAR;
    end else if (roll < 6) begin
      req.kind = KIND_W'($urandom_range(KIND_RSVD_HI, KIND_RSVD_LO));
    end else if (roll < 6 + push_pct * 94 / 100) begin
      req.kind = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    end else begin
      req.kind = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
    end
    case ($urandom_range(7))
      0: req.value = W_MAX;
      1: req.value = W_MIN;
      2: req.value = -32'sd1;
      3: req.value = 32'sd0;
      default: req.value = $urandom;
    endcase
    return req;
  endfunction

  task automatic send_req(in_req_t req, bit typed, out_rsp_t typed_rsp);
    out_rsp_t rsp;
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    rsp = apply_deque_op(req);
    expected_rsps.push_back(typed ? typed_rsp : rsp);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic check_field(string field, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with no request outstanding, expected none, actual %p",
                 $time, out_data);
      end else begin
        oldest_rsp = expected_rsps.pop_front();
        check_field("ok", oldest_rsp.ok, out_data.ok);
        check_field("popped", oldest_rsp.popped, out_data.popped);
        check_field("front_word", oldest_rsp.front_word, out_data.front_word);
        check_field("back_word", oldest_rsp.back_word, out_data.back_word);
        check_field("fill_count", oldest_rsp.fill_count, out_data.fill_count);
        check_field("is_empty", oldest_rsp.is_empty, out_data.is_empty);
        check_field("is_full", oldest_rsp.is_full, out_data.is_full);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int stretch;
    int mode;
    bit held;
    held = 1'b0;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stretch = $urandom_range(40, 4);
      mode = $urandom_range(2);
      repeat (stretch) begin
        if (hold_req && !held) begin
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          held = 1'b1;
          break;
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(1));
          default: out_ready <= ($urandom_range(4) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int sent;
    int burst_left;
    int phase_left;
    int push_pct;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    head = '0;
    count = '0;
    hold_req = 1'b0;
    sent = 0;
    burst_left = 0;
    phase_left = 0;
    push_pct = 50;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
      if ($urandom_range(3) == 0) pause_sender($urandom_range(4, 1));
    end

    while (sent < RANDOM_REQS) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(40, 8);
        case ($urandom_range(2))
          0: push_pct = 75;
          1: push_pct = 25;
          default: push_pct = 50;
        endcase
      end
      if (sent == HOLD_AT) begin
        hold_req = 1'b1;
        push_pct = 75;
      end
      if (sent == SETTLE_AT) begin
        pause_sender(1);
        while (expected_rsps.size() != 0) @(posedge clk);
      end
      send_req(random_deque_req(push_pct), 1'b0, '0);
      sent++;
      phase_left--;
      burst_left--;
      if (burst_left <= 0) begin
        pause_sender($urandom_range(10, 1));
        burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      end
    end

    in_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
